// ===== rtl/lswc_pkg.sv =====
// Shared types and constants for the line segment window clipper.
// Depends on nothing; every other file of the block imports it.

package lswc_pkg;

    // Outcode bits of a point against the clip window.
    localparam int CODE_BITS = 4;
    typedef logic [CODE_BITS-1:0] code_t;

    localparam code_t CODE_LEFT  = 4'b0001;
    localparam code_t CODE_RIGHT = 4'b0010;
    localparam code_t CODE_BELOW = 4'b0100;
    localparam code_t CODE_ABOVE = 4'b1000;

    // Clip steps allowed before a segment is given up as rejected.
    localparam int MAX_PASSES = 8;
    localparam int PASS_BITS  = 4;
    typedef logic [PASS_BITS-1:0] pass_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 8;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_WINDOW_LEFT   = 8'd0;
    localparam cfg_index_t REG_WINDOW_BOTTOM = 8'd1;
    localparam cfg_index_t REG_WINDOW_RIGHT  = 8'd2;
    localparam cfg_index_t REG_WINDOW_TOP    = 8'd3;

endpackage

// ===== rtl/line_segment_window_clipper.sv =====
// Top level of the Cohen-Sutherland line segment window clipper.
// Depends on lswc_pkg, lswc_front, lswc_fifo, lswc_back.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------
//  s_axis   | in        | tvalid / tready        | tdata: start_x, start_y, end_x, end_y
//  m_axis   | out       | tvalid / tready        | tdata: clipped coords; tuser: visible
//  cfg      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (window register)
//
// A transaction on s_axis is registered by the front end, classified
// combinationally from those registers, then written into a two-entry queue.
// The back end takes one segment at a time. A trivially accepted or rejected
// segment is loaded in S_IDLE, decided in S_CHECK and held in S_OUT; every
// clip step runs S_MUL, S_DSTART, S_DIV, S_ADD and S_CODE, with the bit-serial
// divider in S_DIV, and a segment takes at most eight clip steps. Reset clears
// all valid flags and loads the default window. Either side may stall: the
// queue keeps the front end taking transactions while a result waits on m_axis.

module line_segment_window_clipper #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_axis tdata from bit 0: start_x, start_y, end_x, end_y, zero padding.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [8*((4*COORD_BITS+7)/8)-1:0]       s_axis_tdata,
    // m_axis tdata from bit 0: clipped_start_x, clipped_start_y,
    // clipped_end_x, clipped_end_y, zero padding. tuser: visible.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [8*((4*COORD_BITS+7)/8)-1:0]       m_axis_tdata,
    output logic                                    m_axis_tuser,
    // Window configuration writes.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  lswc_pkg::cfg_index_t                    cfg_index,
    input  logic [COORD_BITS-1:0]                   cfg_data
);
    import lswc_pkg::*;

    localparam int FX         = COORD_BITS + FRACTION_BITS;
    localparam int ENTRY_BITS = 4 * FX + 2 * CODE_BITS;
    localparam int DATA_BITS  = 8 * ((4 * COORD_BITS + 7) / 8);
    localparam int PAD_BITS   = DATA_BITS - 4 * COORD_BITS;

    // Window registers; the user must write them only while the block is idle; the block does not enforce it.
    logic signed [COORD_BITS-1:0] window_left_reg;
    logic signed [COORD_BITS-1:0] window_bottom_reg;
    logic signed [COORD_BITS-1:0] window_right_reg;
    logic signed [COORD_BITS-1:0] window_top_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_left_reg   <= COORD_BITS'(100);
            window_bottom_reg <= COORD_BITS'(100);
            window_right_reg  <= COORD_BITS'(300);
            window_top_reg    <= COORD_BITS'(300);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                REG_WINDOW_BOTTOM: window_bottom_reg <= cfg_data;
                REG_WINDOW_RIGHT:  window_right_reg  <= cfg_data;
                REG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front end to queue to back end.
    logic                  push;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop;
    logic [ENTRY_BITS-1:0] pop_data;
    logic                  queue_full;
    logic                  queue_empty;

    lswc_front #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .start_x(s_axis_tdata[COORD_BITS-1:0]),
        .start_y(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .end_x(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .end_y(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .window_left(window_left_reg), .window_bottom(window_bottom_reg),
        .window_right(window_right_reg), .window_top(window_top_reg),
        .push(push), .push_data(push_data), .queue_full(queue_full)
    );

    lswc_fifo #(.WIDTH(ENTRY_BITS), .DEPTH(2)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data),
        .pop(pop), .pop_data(pop_data),
        .full(queue_full), .empty(queue_empty)
    );

    logic signed [COORD_BITS-1:0] clipped_start_x;
    logic signed [COORD_BITS-1:0] clipped_start_y;
    logic signed [COORD_BITS-1:0] clipped_end_x;
    logic signed [COORD_BITS-1:0] clipped_end_y;

    lswc_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .queue_empty(queue_empty), .queue_data(pop_data), .pop(pop),
        .window_left(window_left_reg), .window_bottom(window_bottom_reg),
        .window_right(window_right_reg), .window_top(window_top_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .visible(m_axis_tuser),
        .clipped_start_x(clipped_start_x), .clipped_start_y(clipped_start_y),
        .clipped_end_x(clipped_end_x), .clipped_end_y(clipped_end_y)
    );

    // The padding is empty when four coordinates fill whole bytes.
    generate
        if (PAD_BITS > 0)
        begin : g_pad
            assign m_axis_tdata = {{PAD_BITS{1'b0}}, clipped_end_y, clipped_end_x,
                                   clipped_start_y, clipped_start_x};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {clipped_end_y, clipped_end_x,
                                   clipped_start_y, clipped_start_x};
        end
    endgenerate

endmodule

// ===== rtl/lswc_outcode.sv =====
// Outcode of one fixed-point point against the integer clip window.
// Depends on lswc_pkg.

module lswc_outcode #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic signed [COORD_BITS+FRACTION_BITS-1:0] x,
    input  logic signed [COORD_BITS+FRACTION_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0]               window_left,
    input  logic signed [COORD_BITS-1:0]               window_bottom,
    input  logic signed [COORD_BITS-1:0]               window_right,
    input  logic signed [COORD_BITS-1:0]               window_top,
    output lswc_pkg::code_t                             code
);
    import lswc_pkg::*;

    localparam int FX = COORD_BITS + FRACTION_BITS;

    logic signed [FX-1:0] left_fx;
    logic signed [FX-1:0] bottom_fx;
    logic signed [FX-1:0] right_fx;
    logic signed [FX-1:0] top_fx;

    assign left_fx   = FX'(window_left)   <<< FRACTION_BITS;
    assign bottom_fx = FX'(window_bottom) <<< FRACTION_BITS;
    assign right_fx  = FX'(window_right)  <<< FRACTION_BITS;
    assign top_fx    = FX'(window_top)    <<< FRACTION_BITS;

    // Left wins over right and below over above, as in the classic scheme.
    always_comb
    begin
        code = '0;
        if (x < left_fx)
        begin
            code = code | CODE_LEFT;
        end
        else if (x > right_fx)
        begin
            code = code | CODE_RIGHT;
        end
        if (y < bottom_fx)
        begin
            code = code | CODE_BELOW;
        end
        else if (y > top_fx)
        begin
            code = code | CODE_ABOVE;
        end
    end

endmodule

// ===== rtl/lswc_fifo.sv =====
// Short first-in first-out queue between the front and the back end.
// Depends on lswc_pkg only for the house import convention.

module lswc_fifo #(
    parameter int WIDTH = 104,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import lswc_pkg::*;

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == COUNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (do_push && !do_pop) |=> !empty)
        else $error("queue lost an entry");

endmodule

// ===== rtl/lswc_front.sv =====
// Front end: takes segment transactions, converts endpoints to fixed point
// and classifies them with outcodes. Depends on lswc_pkg and lswc_outcode.

module lswc_front #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [COORD_BITS-1:0]                start_x,
    input  logic signed [COORD_BITS-1:0]                start_y,
    input  logic signed [COORD_BITS-1:0]                end_x,
    input  logic signed [COORD_BITS-1:0]                end_y,
    input  logic signed [COORD_BITS-1:0]                window_left,
    input  logic signed [COORD_BITS-1:0]                window_bottom,
    input  logic signed [COORD_BITS-1:0]                window_right,
    input  logic signed [COORD_BITS-1:0]                window_top,
    output logic                                        push,
    output logic [4*(COORD_BITS+FRACTION_BITS)+2*lswc_pkg::CODE_BITS-1:0] push_data,
    input  logic                                        queue_full
);
    import lswc_pkg::*;

    localparam int FX = COORD_BITS + FRACTION_BITS;

    logic                 hold_valid_reg;
    logic signed [FX-1:0] x1_reg;
    logic signed [FX-1:0] y1_reg;
    logic signed [FX-1:0] x2_reg;
    logic signed [FX-1:0] y2_reg;
    code_t                c1;
    code_t                c2;

    assign push     = hold_valid_reg && !queue_full;
    assign in_ready = !hold_valid_reg || !queue_full;

    lswc_outcode #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_code1 (
        .x(x1_reg), .y(y1_reg),
        .window_left(window_left), .window_bottom(window_bottom),
        .window_right(window_right), .window_top(window_top),
        .code(c1)
    );

    lswc_outcode #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_code2 (
        .x(x2_reg), .y(y2_reg),
        .window_left(window_left), .window_bottom(window_bottom),
        .window_right(window_right), .window_top(window_top),
        .code(c2)
    );

    // Queue entry from the lowest bit: x1, y1, x2, y2, c1, c2.
    assign push_data = {c2, c1, y2_reg, x2_reg, y1_reg, x1_reg};

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x1_reg <= FX'(start_x) <<< FRACTION_BITS;
            y1_reg <= FX'(start_y) <<< FRACTION_BITS;
            x2_reg <= FX'(end_x)   <<< FRACTION_BITS;
            y2_reg <= FX'(end_y)   <<< FRACTION_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/lswc_divider.sv =====
// Restoring divider on magnitudes, one quotient bit per cycle.
// Depends on lswc_pkg only for the house import convention.

module lswc_divider #(
    parameter int NUM_BITS = 50,
    parameter int DEN_BITS = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] numerator,
    input  logic [DEN_BITS-1:0] denominator,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);
    import lswc_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    assign shifted  = {rem_reg, quo_reg[NUM_BITS-1]};
    assign trial    = shifted - {1'b0, den_reg};
    assign fits     = (shifted >= {1'b0, den_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numerator;
            rem_reg <= '0;
            den_reg <= denominator;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/lswc_back.sv =====
// Back end: runs the clip loop on one queued segment with a shared multiplier
// and serial divider, then holds the result. Depends on lswc_pkg, lswc_outcode,
// lswc_divider.

module lswc_back #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        queue_empty,
    input  logic [4*(COORD_BITS+FRACTION_BITS)+2*lswc_pkg::CODE_BITS-1:0] queue_data,
    output logic                                        pop,
    input  logic signed [COORD_BITS-1:0]                window_left,
    input  logic signed [COORD_BITS-1:0]                window_bottom,
    input  logic signed [COORD_BITS-1:0]                window_right,
    input  logic signed [COORD_BITS-1:0]                window_top,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic                                        visible,
    output logic signed [COORD_BITS-1:0]                clipped_start_x,
    output logic signed [COORD_BITS-1:0]                clipped_start_y,
    output logic signed [COORD_BITS-1:0]                clipped_end_x,
    output logic signed [COORD_BITS-1:0]                clipped_end_y
);
    import lswc_pkg::*;

    localparam int FX    = COORD_BITS + FRACTION_BITS;
    localparam int DIFFW = FX + 1;
    localparam int PW    = 2 * DIFFW;
    localparam logic signed [DIFFW-1:0] HALF = DIFFW'((2 ** FRACTION_BITS) / 2);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_MUL, S_DSTART, S_DIV, S_ADD, S_CODE, S_OUT
    } state_t;

    state_t               state_reg;
    logic signed [FX-1:0] x1_reg;
    logic signed [FX-1:0] y1_reg;
    logic signed [FX-1:0] x2_reg;
    logic signed [FX-1:0] y2_reg;
    code_t                c1_reg;
    code_t                c2_reg;
    pass_t                pass_reg;
    logic                 first_reg;
    logic                 vert_reg;
    logic signed [FX-1:0] edge_reg;
    logic signed [FX-1:0] base_reg;
    logic signed [DIFFW-1:0] mul_a_reg;
    logic signed [DIFFW-1:0] mul_b_reg;
    logic signed [DIFFW-1:0] den_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    neg_reg;
    logic                    out_valid_reg;
    logic                    visible_reg;
    logic signed [COORD_BITS-1:0] csx_reg;
    logic signed [COORD_BITS-1:0] csy_reg;
    logic signed [COORD_BITS-1:0] cex_reg;
    logic signed [COORD_BITS-1:0] cey_reg;

    // Fixed-point window edges and saturation bounds.
    logic signed [FX-1:0] left_fx;
    logic signed [FX-1:0] bottom_fx;
    logic signed [FX-1:0] right_fx;
    logic signed [FX-1:0] top_fx;
    logic signed [PW:0]   sat_hi;
    logic signed [PW:0]   sat_lo;

    assign left_fx   = FX'(window_left)   <<< FRACTION_BITS;
    assign bottom_fx = FX'(window_bottom) <<< FRACTION_BITS;
    assign right_fx  = FX'(window_right)  <<< FRACTION_BITS;
    assign top_fx    = FX'(window_top)    <<< FRACTION_BITS;
    assign sat_hi    = (PW + 1)'({1'b0, {(COORD_BITS-1){1'b1}}}) <<< FRACTION_BITS;
    assign sat_lo    = (PW + 1)'($signed({1'b1, {(COORD_BITS-1){1'b0}}})) <<< FRACTION_BITS;

    // Clip step decisions taken in S_CHECK.
    code_t                co;
    logic                 pick_first;
    logic                 is_vert;
    logic signed [FX-1:0] edge_sel;
    logic signed [DIFFW-1:0] den_sel;
    logic                    both_in;
    logic                    reject;

    assign pick_first = (c1_reg != '0);
    assign co         = pick_first ? c1_reg : c2_reg;
    assign is_vert    = ((co & (CODE_ABOVE | CODE_BELOW)) != '0);
    assign both_in    = (c1_reg == '0) && (c2_reg == '0);

    always_comb
    begin
        if (is_vert)
        begin
            edge_sel = ((co & CODE_ABOVE) != '0) ? top_fx : bottom_fx;
            den_sel  = DIFFW'(y2_reg) - DIFFW'(y1_reg);
        end
        else
        begin
            edge_sel = ((co & CODE_RIGHT) != '0) ? right_fx : left_fx;
            den_sel  = DIFFW'(x2_reg) - DIFFW'(x1_reg);
        end
    end

    assign reject = ((c1_reg & c2_reg) != '0) || (pass_reg == PASS_BITS'(MAX_PASSES))
                    || (den_sel == '0);

    // Divider on magnitudes; the sign is put back afterwards.
    logic [PW-1:0]    num_mag;
    logic [DIFFW-1:0] den_mag;
    logic [PW-1:0]    quo_mag;
    logic             div_done;
    logic signed [PW-1:0] quo_signed;
    logic signed [PW:0]   sum;
    logic signed [FX-1:0] sum_sat;

    assign num_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign den_mag = den_reg[DIFFW-1] ? DIFFW'(-den_reg) : DIFFW'(den_reg);

    lswc_divider #(.NUM_BITS(PW), .DEN_BITS(DIFFW)) u_div (
        .clk(clk), .rst_n(rst_n),
        .start(state_reg == S_DSTART),
        .numerator(num_mag), .denominator(den_mag),
        .done(div_done), .quotient(quo_mag)
    );

    assign quo_signed = neg_reg ? -$signed(quo_mag) : $signed(quo_mag);
    assign sum        = (PW + 1)'(base_reg) + (PW + 1)'(quo_signed);
    assign sum_sat    = (sum > sat_hi) ? FX'(sat_hi) : ((sum < sat_lo) ? FX'(sat_lo) : FX'(sum));

    // Outcode of the endpoint that was just moved.
    code_t moved_code;

    lswc_outcode #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_code (
        .x(first_reg ? x1_reg : x2_reg), .y(first_reg ? y1_reg : y2_reg),
        .window_left(window_left), .window_bottom(window_bottom),
        .window_right(window_right), .window_top(window_top),
        .code(moved_code)
    );

    // Round half up: add one half, then floor by an arithmetic shift.
    function automatic logic signed [COORD_BITS-1:0] round_out(input logic signed [FX-1:0] v);
        logic signed [DIFFW-1:0] t;
        begin
            t = DIFFW'(v) + HALF;
            return COORD_BITS'(t >>> FRACTION_BITS);
        end
    endfunction

    assign pop             = (state_reg == S_IDLE) && !queue_empty;
    assign out_valid       = out_valid_reg;
    assign visible         = visible_reg;
    assign clipped_start_x = csx_reg;
    assign clipped_start_y = csy_reg;
    assign clipped_end_x   = cex_reg;
    assign clipped_end_y   = cey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pass_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        {c2_reg, c1_reg, y2_reg, x2_reg, y1_reg, x1_reg} <= queue_data;
                        pass_reg  <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (both_in)
                    begin
                        visible_reg   <= 1'b1;
                        csx_reg       <= round_out(x1_reg);
                        csy_reg       <= round_out(y1_reg);
                        cex_reg       <= round_out(x2_reg);
                        cey_reg       <= round_out(y2_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else if (reject)
                    begin
                        visible_reg   <= 1'b0;
                        csx_reg       <= '0;
                        csy_reg       <= '0;
                        cex_reg       <= '0;
                        cey_reg       <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        first_reg <= pick_first;
                        vert_reg  <= is_vert;
                        edge_reg  <= edge_sel;
                        den_reg   <= den_sel;
                        if (is_vert)
                        begin
                            mul_a_reg <= DIFFW'(x2_reg) - DIFFW'(x1_reg);
                            mul_b_reg <= DIFFW'(edge_sel) - DIFFW'(y1_reg);
                            base_reg  <= x1_reg;
                        end
                        else
                        begin
                            mul_a_reg <= DIFFW'(y2_reg) - DIFFW'(y1_reg);
                            mul_b_reg <= DIFFW'(edge_sel) - DIFFW'(x1_reg);
                            base_reg  <= y1_reg;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_a_reg * mul_b_reg;
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    neg_reg   <= prod_reg[PW-1] ^ den_reg[DIFFW-1];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    if (first_reg)
                    begin
                        x1_reg <= vert_reg ? sum_sat : edge_reg;
                        y1_reg <= vert_reg ? edge_reg : sum_sat;
                    end
                    else
                    begin
                        x2_reg <= vert_reg ? sum_sat : edge_reg;
                        y2_reg <= vert_reg ? edge_reg : sum_sat;
                    end
                    pass_reg  <= pass_reg + 1'b1;
                    state_reg <= S_CODE;
                end
                S_CODE:
                begin
                    if (first_reg)
                    begin
                        c1_reg <= moved_code;
                    end
                    else
                    begin
                        c2_reg <= moved_code;
                    end
                    state_reg <= S_CHECK;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_DIV) |-> (den_reg != '0))
        else $error("division started with a zero divisor");
    assert property (@(posedge clk) disable iff (!rst_n)
                     pass_reg <= PASS_BITS'(MAX_PASSES))
        else $error("clip loop ran past its pass limit");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (out_valid_reg && !visible_reg) |->
                     (csx_reg == '0 && csy_reg == '0 && cex_reg == '0 && cey_reg == '0))
        else $error("rejected segment carries nonzero coordinates");
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid_reg |-> (state_reg == S_OUT))
        else $error("result valid outside the output state");

endmodule

// ===== tb/tb_line_segment_window_clipper.sv =====
// Self-checking testbench for the Cohen-Sutherland line segment window clipper.
// Depends on lswc_pkg and line_segment_window_clipper; it predicts every clipped
// segment in a scoreboard class and compares it with the m_axis output.
`timescale 1ns / 100ps

module tb_line_segment_window_clipper;
    import lswc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 8;
    localparam int LIMIT_CYCLES = 1500000;
    localparam int HOLD_OFF_LEN = 800;

    typedef struct packed {
        logic signed [CB-1:0] ey;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] sx;
    } seg_t;

    typedef struct {
        logic          visible;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
    } clip_t;

    // Scoreboard: holds the window and a queue of predicted clipped segments.
    class clip_scoreboard;
        longint win_l, win_b, win_r, win_t;
        clip_t  pending[$];
        int     mismatches;

        function new();
            win_l = 100;
            win_b = 100;
            win_r = 300;
            win_t = 300;
            mismatches = 0;
        endfunction

        function void set_window(cfg_index_t idx, logic signed [CB-1:0] v);
            case (idx)
                REG_WINDOW_LEFT:   win_l = v;
                REG_WINDOW_BOTTOM: win_b = v;
                REG_WINDOW_RIGHT:  win_r = v;
                REG_WINDOW_TOP:    win_t = v;
                default: ;
            endcase
        endfunction

        function code_t region(longint x, longint y);
            code_t c;
            c = '0;
            if (x < (win_l <<< FB)) c |= CODE_LEFT;
            else if (x > (win_r <<< FB)) c |= CODE_RIGHT;
            if (y < (win_b <<< FB)) c |= CODE_BELOW;
            else if (y > (win_t <<< FB)) c |= CODE_ABOVE;
            return c;
        endfunction

        function longint clamp(longint v);
            longint hi;
            longint lo;
            hi = ((longint'(1) <<< (CB - 1)) - 1) <<< FB;
            lo = -(longint'(1) <<< (CB - 1)) <<< FB;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        // Round half up; a right shift of a signed value floors.
        function logic [CB-1:0] to_pixel(longint v);
            longint t;
            t = (v + (longint'(1) <<< (FB - 1))) >>> FB;
            return t[CB-1:0];
        endfunction

        function void note_segment(seg_t s);
            longint x1, y1, x2, y2, nx, ny, den, edge_v;
            code_t  c1, c2, co;
            bit     ok, first;
            clip_t  r;
            x1 = longint'(s.sx) <<< FB;
            y1 = longint'(s.sy) <<< FB;
            x2 = longint'(s.ex) <<< FB;
            y2 = longint'(s.ey) <<< FB;
            c1 = region(x1, y1);
            c2 = region(x2, y2);
            ok = 0;
            for (int p = 0; p <= MAX_PASSES; p++) begin
                if (c1 == 0 && c2 == 0) begin
                    ok = 1;
                    break;
                end
                if ((c1 & c2) != 0 || p == MAX_PASSES) break;
                first = (c1 != 0);
                co = first ? c1 : c2;
                // Vertical edges first: move onto top or bottom.
                if (co & (CODE_ABOVE | CODE_BELOW)) begin
                    edge_v = ((co & CODE_ABOVE) ? win_t : win_b) <<< FB;
                    den = y2 - y1;
                    if (den == 0) break;
                    nx = clamp(x1 + ((x2 - x1) * (edge_v - y1)) / den);
                    ny = edge_v;
                end else begin
                    edge_v = ((co & CODE_RIGHT) ? win_r : win_l) <<< FB;
                    den = x2 - x1;
                    if (den == 0) break;
                    ny = clamp(y1 + ((y2 - y1) * (edge_v - x1)) / den);
                    nx = edge_v;
                end
                if (first) begin
                    x1 = nx; y1 = ny; c1 = region(x1, y1);
                end else begin
                    x2 = nx; y2 = ny; c2 = region(x2, y2);
                end
            end
            r.visible = ok;
            r.sx = ok ? to_pixel(x1) : '0;
            r.sy = ok ? to_pixel(y1) : '0;
            r.ex = ok ? to_pixel(x2) : '0;
            r.ey = ok ? to_pixel(y2) : '0;
            pending.push_back(r);
        endfunction

        function void check_result(logic vis, logic [4*CB-1:0] d);
            clip_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: tdata=%h", d);
                return;
            end
            e = pending.pop_front();
            if (vis !== e.visible || d[CB-1:0] !== e.sx || d[2*CB-1:CB] !== e.sy
                || d[3*CB-1:2*CB] !== e.ex || d[4*CB-1:3*CB] !== e.ey) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected vis=%0d (%0d,%0d)-(%0d,%0d) got vis=%0d (%0d,%0d)-(%0d,%0d)",
                        e.visible, $signed(e.sx), $signed(e.sy), $signed(e.ex), $signed(e.ey),
                        vis, $signed(d[CB-1:0]), $signed(d[2*CB-1:CB]),
                        $signed(d[3*CB-1:2*CB]), $signed(d[4*CB-1:3*CB]));
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [4*CB-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [4*CB-1:0]  m_axis_tdata;
    logic             m_axis_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CB-1:0]    cfg_data;

    clip_scoreboard board;
    int  send_idle_pct;    // chance per cycle that the sender holds back
    int  recv_stall_pct;   // chance per cycle that the receiver stalls
    bit  hold_off_go;      // asks the receiver for one long hold-off
    logic hold_off_taken;  // the receiver has started that hold-off
    int  hold_off_cycles;  // long receiver hold-off, counted in its own process
    longint cycle_count = 0;

    line_segment_window_clipper #(.COORD_BITS(CB), .FRACTION_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready   <= 1'b0;
            hold_off_taken  <= 1'b0;
            hold_off_cycles <= 0;
        end else if (hold_off_go && !hold_off_taken) begin
            hold_off_taken  <= 1'b1;
            hold_off_cycles <= HOLD_OFF_LEN;
            m_axis_tready   <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor: every m_axis transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one segment, idling beforehand at the current rate, and returns
    // once the transaction has been taken. The offer stays up until the next
    // idle cycle or the next drain.
    task automatic send_segment(seg_t s);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_segment(s);
    endtask

    task automatic write_window(cfg_index_t idx, logic [CB-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_window(idx, v);
    endtask

    task automatic set_window_all(logic [CB-1:0] l, logic [CB-1:0] b,
                                  logic [CB-1:0] r, logic [CB-1:0] t);
        write_window(REG_WINDOW_LEFT, l);
        write_window(REG_WINDOW_BOTTOM, b);
        write_window(REG_WINDOW_RIGHT, r);
        write_window(REG_WINDOW_TOP, t);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every predicted result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [CB-1:0] coord_near(longint lo, longint hi);
        longint v;
        case ($urandom_range(7))
            0: v = $signed(CB'($urandom));
            1: v = lo - $urandom_range(3);
            2: v = hi + $urandom_range(3);
            default: v = lo - 200 + $urandom_range(int'(hi - lo + 400));
        endcase
        return v[CB-1:0];
    endfunction

    // Random segment around the current window, mostly ones that need clipping.
    function automatic seg_t random_segment();
        seg_t s;
        s.sx = coord_near(board.win_l, board.win_r);
        s.sy = coord_near(board.win_b, board.win_t);
        s.ex = coord_near(board.win_l, board.win_r);
        s.ey = coord_near(board.win_b, board.win_t);
        return s;
    endfunction

    task automatic run_phase(int idle, int stall, int count);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) send_segment(random_segment());
    endtask

    initial
    begin
        seg_t s;
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LEFT;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_go = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments against the reset window: inside, trivial reject,
        // clipping on each edge, both ends outside, vertical and horizontal lines,
        // and the extremes of the coordinate range.
        s = '{16'sd300, 16'sd250, 16'sd100, 16'sd150}; send_segment(s);
        s = '{16'sd20, 16'sd10, 16'sd40, 16'sd5};      send_segment(s);
        s = '{16'sd350, 16'sd400, 16'sd200, 16'sd200}; send_segment(s);
        s = '{16'sd0, 16'sd150, 16'sd200, 16'sd200};   send_segment(s);
        s = '{16'sd150, 16'sd0, 16'sd150, 16'sd200};   send_segment(s);
        s = '{16'sd200, 16'sd0, 16'sd200, 16'sd500};   send_segment(s);
        s = '{16'sd500, 16'sd200, 16'sd0, 16'sd200};   send_segment(s);
        s = '{16'sd333, 16'sd401, 16'sd7, 16'sd13};    send_segment(s);
        s = '{16'sd50, 16'sd350, 16'sd350, 16'sd50};   send_segment(s);
        s = '{16'sd0, 16'sd250, 16'sd250, 16'sd0};     send_segment(s);
        s = '{16'h7fff, 16'h7fff, 16'sh8000, 16'sh8000}; send_segment(s);
        s = '{16'sh8000, 16'h7fff, 16'h7fff, 16'sh8000}; send_segment(s);
        s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; send_segment(s);
        s = '{16'sd301, 16'sd99, 16'sd99, 16'sd301};   send_segment(s);
        drain();

        // Extreme window: the whole coordinate range, where crossings saturate.
        set_window_all(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        s = '{16'h7fff, 16'sh8000, 16'sh8000, 16'h7fff}; send_segment(s);
        run_phase(0, 0, 15);
        drain();

        // Inverted window: zero divisors and the pass limit become reachable.
        set_window_all(16'sd200, 16'sd200, 16'sd100, 16'sd100);
        s = '{16'sd150, 16'sd50, 16'sd150, 16'sd250}; send_segment(s);
        s = '{16'sd50, 16'sd150, 16'sd250, 16'sd150}; send_segment(s);
        run_phase(0, 0, 20);
        drain();

        // Degenerate one-pixel window at the origin.
        set_window_all(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        run_phase(57, 0, 30);
        drain();

        set_window_all(16'shfe0c, 16'sd100, 16'sd30, 16'sd900);
        run_phase(0, 57, 60);
        // Long receiver hold-off while the sender keeps offering segments.
        hold_off_go = 1'b1;
        run_phase(0, 0, 20);
        drain();

        set_window_all(16'sd100, 16'sd100, 16'sd300, 16'sd300);
        run_phase(26, 26, 120);
        run_phase(0, 0, 118);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
